// ===== sv/ple_pkg.sv =====
// Shared types, codes and sizes for the positional list engine.
`timescale 1ns / 1ps
`default_nettype none

package ple_pkg;

   localparam int DEPTH       = 16;
   localparam int DATA_WIDTH  = 32;
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int POS_W       = 5;
   localparam int IDX_W       = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
   localparam int VALUE_W     = 32;
   localparam int ELEM_W      = 32;
   localparam int LEN_W       = 5;
   localparam int MODE_W      = 3;
   localparam int STATUS_W    = 2;
   localparam int REQ_TDATA_W = 40;
   localparam int REQ_PAD_W   = REQ_TDATA_W - VALUE_W - POS_W;
   localparam int RSP_TDATA_W = 40;
   localparam int RSP_PAD_W   = RSP_TDATA_W - STATUS_W - ELEM_W - LEN_W;

   typedef logic [DATA_WIDTH-1:0] data_type;
   typedef logic [CNT_W-1:0]      cnt_type;
   typedef logic [IDX_W-1:0]      idx_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_INS_FRONT = 3'd0,
      MODE_INS_BACK  = 3'd1,
      MODE_INS_AT    = 3'd2,
      MODE_DEL_FRONT = 3'd3,
      MODE_DEL_BACK  = 3'd4,
      MODE_DEL_AT    = 3'd5,
      MODE_DUMP      = 3'd6
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 2'd0,
      ST_BADPOS = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   // What a cell takes at the next edge.
   typedef enum logic [1:0] {
      CELL_HOLD  = 2'd0,
      CELL_LEFT  = 2'd1,
      CELL_RIGHT = 2'd2,
      CELL_LOAD  = 2'd3
   } cell_cmd_type;

endpackage

`default_nettype wire

// ===== sv/positional_list_engine.sv =====
// Top level of the positional list engine: decode, cell row, dump sequencer, output register.
//
//   channel | dir | handshake              | payload
//   --------+-----+------------------------+---------------------------------------------
//   req     | in  | req_tvalid/req_tready  | tuser mode; tdata value, position
//   rsp     | out | rsp_tvalid/rsp_tready  | tuser has_element; tdata status, element,
//           |     | rsp_tlast              |   length; tlast marks the final response
//
// In an edit (insert or delete) every cell shifts or holds in parallel and the single
// response is registered at the same edge, so edits can follow back to back. A dump
// gives one response per entry per cycle while rsp_tready holds, by rotating the occupied
// cells toward the front through cell 0; after count rotations the list is back in order.
// While a dump runs no request is taken. A stalled response holds the output register and
// stalls the request side. Reset clears the count and the control state; cell contents
// are left as they are and are never read before written.
`timescale 1ns / 1ps
`default_nettype none

module positional_list_engine (
   input  wire                               clock,
   input  wire                               reset,
   // req: slave side
   input  wire                               req_tvalid,
   output logic                              req_tready,
   input  wire [ple_pkg::REQ_TDATA_W-1:0]    req_tdata,  // [31:0] value, [36:32] position
   input  wire [ple_pkg::MODE_W-1:0]         req_tuser,  // [2:0] mode
   // rsp: master side
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   output logic [ple_pkg::RSP_TDATA_W-1:0]   rsp_tdata,  // [1:0] status, [33:2] element,
                                                         // [38:34] length
   output logic                              rsp_tuser,  // [0] has_element
   output logic                              rsp_tlast
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_DUMP = 2'b10
   } state_type;

   state_type state_ff, state_in;
   ple_pkg::cnt_type count_ff, count_in;
   ple_pkg::cnt_type left_ff, left_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   ple_pkg::status_type               status_ff, status_in;
   logic [ple_pkg::ELEM_W-1:0]        elem_ff, elem_in;
   logic                              has_ff, has_in;
   logic [ple_pkg::LEN_W-1:0]         len_ff, len_in;
   logic                              last_ff, last_in;

   // request fields
   ple_pkg::mode_type                 mode;
   ple_pkg::data_type                 value_d;
   logic [ple_pkg::POS_W-1:0]         pos;
   ple_pkg::idx_type                  pos_x;
   ple_pkg::idx_type                  cnt_x;

   // decode results
   logic                              do_ins, do_del;
   ple_pkg::idx_type                  idx;
   ple_pkg::status_type               edit_status;

   logic                              slot_free, accept;
   logic                              ins_go, del_go;
   logic                              dump_start, emit, emit_last;
   logic                              full;

   ple_pkg::data_type                 cell_data [ple_pkg::DEPTH];
   ple_pkg::cell_cmd_type             cell_cmd  [ple_pkg::DEPTH];
   ple_pkg::data_type                 load_data;

   assign mode    = ple_pkg::mode_type'(req_tuser);
   assign value_d = ple_pkg::DATA_WIDTH'(req_tdata[ple_pkg::VALUE_W-1:0]);
   assign pos     = req_tdata[ple_pkg::VALUE_W +: ple_pkg::POS_W];
   assign pos_x   = ple_pkg::IDX_W'(pos);
   assign cnt_x   = ple_pkg::IDX_W'(count_ff);
   assign full    = (count_ff == ple_pkg::CNT_W'(ple_pkg::DEPTH));

   // handshake: take a request only when idle and the output slot frees this cycle
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && slot_free;
   assign accept     = req_tvalid && req_tready;

   // decode the edit: which cell index it touches and what status it reports
   always_comb begin
      do_ins      = 1'b0;
      do_del      = 1'b0;
      idx         = '0;
      edit_status = ple_pkg::ST_OK;
      case (mode)
         ple_pkg::MODE_INS_FRONT: begin
            if (full) begin
               edit_status = ple_pkg::ST_FULL;
            end else begin
               do_ins = 1'b1;
            end
         end
         ple_pkg::MODE_INS_BACK: begin
            if (full) begin
               edit_status = ple_pkg::ST_FULL;
            end else begin
               do_ins = 1'b1;
               idx    = cnt_x;
            end
         end
         ple_pkg::MODE_INS_AT: begin
            // position check comes before the full check
            if (pos_x == '0 || pos_x > cnt_x + ple_pkg::IDX_W'(1)) begin
               edit_status = ple_pkg::ST_BADPOS;
            end else if (full) begin
               edit_status = ple_pkg::ST_FULL;
            end else begin
               do_ins = 1'b1;
               idx    = pos_x - ple_pkg::IDX_W'(1);
            end
         end
         ple_pkg::MODE_DEL_FRONT: begin
            if (count_ff == '0) begin
               edit_status = ple_pkg::ST_EMPTY;
            end else begin
               do_del = 1'b1;
            end
         end
         ple_pkg::MODE_DEL_BACK: begin
            if (count_ff == '0) begin
               edit_status = ple_pkg::ST_EMPTY;
            end else begin
               do_del = 1'b1;
               idx    = cnt_x - ple_pkg::IDX_W'(1);
            end
         end
         ple_pkg::MODE_DEL_AT: begin
            // an empty list makes every position bad
            if (pos_x == '0 || pos_x > cnt_x) begin
               edit_status = ple_pkg::ST_BADPOS;
            end else begin
               do_del = 1'b1;
               idx    = pos_x - ple_pkg::IDX_W'(1);
            end
         end
         default: begin
            // dump and the unused code change nothing here
         end
      endcase
   end

   assign ins_go     = accept && do_ins;
   assign del_go     = accept && do_del;
   assign dump_start = accept && (mode == ple_pkg::MODE_DUMP) && (count_ff != '0);
   assign emit       = dump_start || ((state_ff == S_DUMP) && slot_free);
   assign emit_last  = (state_ff == S_DUMP) ? (left_ff == ple_pkg::CNT_W'(1))
                                            : (count_ff == ple_pkg::CNT_W'(1));

   // a rotating dump wraps cell 0 into the last occupied cell
   assign load_data = emit ? cell_data[0] : value_d;

   // cell row
   for (genvar i = 0; i < ple_pkg::DEPTH; i++) begin : g_cell
      ple_pkg::data_type left_d;
      ple_pkg::data_type right_d;

      if (i == 0) begin : g_first
         assign left_d = cell_data[i];
      end else begin : g_mid_l
         assign left_d = cell_data[i-1];
      end

      if (i == ple_pkg::DEPTH - 1) begin : g_final
         assign right_d = cell_data[i];
      end else begin : g_mid_r
         assign right_d = cell_data[i+1];
      end

      always_comb begin
         cell_cmd[i] = ple_pkg::CELL_HOLD;
         if (ins_go) begin
            // open a gap at idx: later cells move one place back
            if (ple_pkg::IDX_W'(i) > idx) begin
               cell_cmd[i] = ple_pkg::CELL_LEFT;
            end else if (ple_pkg::IDX_W'(i) == idx) begin
               cell_cmd[i] = ple_pkg::CELL_LOAD;
            end
         end else if (del_go) begin
            // close the gap at idx: later cells move one place forward
            if (ple_pkg::IDX_W'(i) >= idx && i < ple_pkg::DEPTH - 1) begin
               cell_cmd[i] = ple_pkg::CELL_RIGHT;
            end
         end else if (emit) begin
            if (ple_pkg::IDX_W'(i) == cnt_x - ple_pkg::IDX_W'(1)) begin
               cell_cmd[i] = ple_pkg::CELL_LOAD;
            end else if (ple_pkg::IDX_W'(i) < cnt_x - ple_pkg::IDX_W'(1)) begin
               cell_cmd[i] = ple_pkg::CELL_RIGHT;
            end
         end
      end

      ple_cell u_cell (
         .clock      (clock),
         .cmd        (cell_cmd[i]),
         .left_data  (left_d),
         .right_data (right_d),
         .load_data  (load_data),
         .data_out   (cell_data[i])
      );
   end

   // count, dump sequencer and output register
   always_comb begin
      count_in     = count_ff;
      state_in     = state_ff;
      left_in      = left_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      elem_in      = elem_ff;
      has_in       = has_ff;
      len_in       = len_ff;
      last_in      = last_ff;

      if (ins_go) begin
         count_in = count_ff + ple_pkg::CNT_W'(1);
      end else if (del_go) begin
         count_in = count_ff - ple_pkg::CNT_W'(1);
      end

      if (emit) begin
         // send cell 0 and advance the rotation
         rsp_valid_in = 1'b1;
         status_in    = ple_pkg::ST_OK;
         elem_in      = ple_pkg::ELEM_W'(cell_data[0]);
         has_in       = 1'b1;
         len_in       = ple_pkg::LEN_W'(count_ff);
         last_in      = emit_last;
         if (dump_start) begin
            left_in  = count_ff - ple_pkg::CNT_W'(1);
            state_in = emit_last ? S_IDLE : S_DUMP;
         end else begin
            left_in  = left_ff - ple_pkg::CNT_W'(1);
            state_in = emit_last ? S_IDLE : S_DUMP;
         end
      end else if (accept) begin
         // one response for every edit, an empty dump or the unused code
         rsp_valid_in = 1'b1;
         status_in    = edit_status;
         elem_in      = '0;
         has_in       = 1'b0;
         len_in       = ple_pkg::LEN_W'(count_in);
         last_in      = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      elem_ff   <= elem_in;
      has_ff    <= has_in;
      len_ff    <= len_in;
      last_ff   <= last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{ple_pkg::RSP_PAD_W{1'b0}}, len_ff, elem_ff, status_ff};
   assign rsp_tuser  = has_ff;
   assign rsp_tlast  = last_ff;

endmodule

`default_nettype wire

// ===== sv/ple_cell.sv =====
// One storage cell of the list row: hold, take a neighbor, or load.
`timescale 1ns / 1ps
`default_nettype none

module ple_cell (
   input  wire                  clock,
   input  ple_pkg::cell_cmd_type cmd,
   input  ple_pkg::data_type     left_data,
   input  ple_pkg::data_type     right_data,
   input  ple_pkg::data_type     load_data,
   output ple_pkg::data_type     data_out
);

   ple_pkg::data_type data_ff;
   ple_pkg::data_type data_in;

   always_comb begin
      case (cmd)
         ple_pkg::CELL_HOLD:  data_in = data_ff;
         ple_pkg::CELL_LEFT:  data_in = left_data;
         ple_pkg::CELL_RIGHT: data_in = right_data;
         ple_pkg::CELL_LOAD:  data_in = load_data;
         default:             data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule

`default_nettype wire

// ===== sv/ple_checker.sv =====
// Port-level checks for the positional list engine, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ple_checker (
   input wire                             clock,
   input wire                             reset,
   input wire                             req_tvalid,
   input wire                             req_tready,
   input wire                             rsp_tvalid,
   input wire                             rsp_tready,
   input wire [ple_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input wire                             rsp_tuser,
   input wire                             rsp_tlast
);

   // every accepted request shows a response on the next cycle
   a_req_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted request produced no response");

   // a response without an element is a single, final one with zero element
   a_plain_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast && (rsp_tdata[33:2] == '0))
      else $error("plain response not last or element not zero");

   // a dump entry always reports success
   a_dump_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> (rsp_tdata[1:0] == ple_pkg::ST_OK))
      else $error("dump entry with failing status");

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled response changed");

endmodule

bind positional_list_engine ple_checker u_ple_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

// ===== tb/positional_list_engine_tb.sv =====
// Self-checking testbench for the positional list engine: queued requests, shadow list, checker.
`timescale 1ns / 1ps

module positional_list_engine_tb;

   localparam logic [ple_pkg::MODE_W-1:0] MODE_UNUSED = 3'd7;  // outside the decoded set
   localparam int RSP_ELEM_LO = ple_pkg::STATUS_W;
   localparam int RSP_LEN_LO  = ple_pkg::STATUS_W + ple_pkg::ELEM_W;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 40;

   typedef struct {
      logic [ple_pkg::MODE_W-1:0]  mode;
      logic [ple_pkg::VALUE_W-1:0] value;
      logic [ple_pkg::POS_W-1:0]   position;
      bit                          pause;     // marker: hold the sender until all responses are in
      int unsigned                 tx_idle;   // percent of cycles the sender idles
      int unsigned                 rx_stall;  // percent of cycles the receiver stalls
   } list_request_type;

   typedef struct {
      ple_pkg::status_type         status;
      logic [ple_pkg::ELEM_W-1:0]  element;
      logic                        has_element;
      logic [ple_pkg::LEN_W-1:0]   length;
      logic                        last;
   } list_rsp_type;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [ple_pkg::REQ_TDATA_W-1:0] req_tdata  = '0;  // [31:0] value, [36:32] position
   logic [ple_pkg::MODE_W-1:0]      req_tuser  = '0;  // [2:0] mode
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [ple_pkg::RSP_TDATA_W-1:0] rsp_tdata;  // [1:0] status, [33:2] element, [38:34] length
   logic                            rsp_tuser;  // [0] has_element
   logic                            rsp_tlast;

   list_request_type pending_reqs[$];
   list_request_type req_in_flight;
   list_rsp_type     expected_rsps[$];

   // shadow of the list contents
   ple_pkg::data_type list_cells[ple_pkg::DEPTH];
   int                list_len = 0;

   int unsigned   gen_tx_idle  = 0;
   int unsigned   gen_rx_stall = 0;
   int unsigned   rx_stall_pct = 0;
   int            fail_count   = 0;
   int            cycle_count  = 0;

   positional_list_engine i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- shadow list

   function automatic void insert_cell(int idx, ple_pkg::data_type v);
      for (int i = list_len; i > idx; i--) list_cells[i] = list_cells[i-1];
      list_cells[idx] = v;
      list_len++;
   endfunction

   function automatic void remove_cell(int idx);
      for (int i = idx; i + 1 < list_len; i++) list_cells[i] = list_cells[i+1];
      list_len--;
   endfunction

   function automatic void push_rsp(ple_pkg::status_type st, ple_pkg::data_type el, logic has,
                                    logic last);
      list_rsp_type r;
      r.status      = st;
      r.element     = el;
      r.has_element = has;
      r.length      = list_len[ple_pkg::LEN_W-1:0];
      r.last        = last;
      expected_rsps.push_back(r);
   endfunction

   // Apply one accepted request to the shadow list and queue what it should return.
   function automatic void predict_list_op(list_request_type r);
      ple_pkg::status_type st;
      int                  pos;
      st  = ple_pkg::ST_OK;
      pos = int'(r.position);
      case (r.mode)
         ple_pkg::MODE_INS_FRONT, ple_pkg::MODE_INS_BACK: begin
            if (list_len >= ple_pkg::DEPTH) st = ple_pkg::ST_FULL;
            else insert_cell((r.mode == ple_pkg::MODE_INS_FRONT) ? 0 : list_len, r.value);
         end
         ple_pkg::MODE_INS_AT: begin
            // the position check wins over the full check
            if (pos < 1 || pos > list_len + 1) st = ple_pkg::ST_BADPOS;
            else if (list_len >= ple_pkg::DEPTH) st = ple_pkg::ST_FULL;
            else insert_cell(pos - 1, r.value);
         end
         ple_pkg::MODE_DEL_FRONT, ple_pkg::MODE_DEL_BACK: begin
            if (list_len == 0) st = ple_pkg::ST_EMPTY;
            else remove_cell((r.mode == ple_pkg::MODE_DEL_FRONT) ? 0 : list_len - 1);
         end
         ple_pkg::MODE_DEL_AT: begin
            if (pos < 1 || pos > list_len) st = ple_pkg::ST_BADPOS;
            else remove_cell(pos - 1);
         end
         ple_pkg::MODE_DUMP: begin
            if (list_len > 0) begin
               for (int i = 0; i < list_len; i++)
                  push_rsp(ple_pkg::ST_OK, list_cells[i], 1'b1, i + 1 == list_len);
               return;
            end
         end
         default: ;
      endcase
      push_rsp(st, '0, 1'b0, 1'b1);
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   function automatic void add_request(logic [ple_pkg::MODE_W-1:0] mode,
                                       logic [ple_pkg::VALUE_W-1:0] value,
                                       logic [ple_pkg::POS_W-1:0] position);
      list_request_type r;
      r.mode     = mode;
      r.value    = value;
      r.position = position;
      r.pause    = 1'b0;
      r.tx_idle  = gen_tx_idle;
      r.rx_stall = gen_rx_stall;
      pending_reqs.push_back(r);
   endfunction

   function automatic void add_pause();
      list_request_type r;
      r          = '{default: '0};
      r.pause    = 1'b1;
      pending_reqs.push_back(r);
   endfunction

   function automatic logic [ple_pkg::VALUE_W-1:0] pick_value();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // One phase of random traffic; ins_pct biases toward growing or shrinking the list.
   function automatic void add_random_phase(int unsigned tx_idle, int unsigned rx_stall,
                                            int unsigned ins_pct, int count);
      int unsigned                roll;
      logic [ple_pkg::MODE_W-1:0] mode;
      logic [ple_pkg::POS_W-1:0]  pos;
      gen_tx_idle  = tx_idle;
      gen_rx_stall = rx_stall;
      add_pause();
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         if (roll < 10) mode = ple_pkg::MODE_DUMP;
         else if ($urandom_range(99) < ins_pct)
            mode = ple_pkg::MODE_W'(int'(ple_pkg::MODE_INS_FRONT) + $urandom_range(2));
         else
            mode = ple_pkg::MODE_W'(int'(ple_pkg::MODE_DEL_FRONT) + $urandom_range(2));
         // mostly near the legal range, sometimes anywhere in the field
         pos = ($urandom_range(99) < 85) ? ple_pkg::POS_W'($urandom_range(17))
                                         : ple_pkg::POS_W'($urandom_range(31));
         add_request(mode, pick_value(), pos);
      end
   endfunction

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) predict_list_op(req_in_flight);
         if (!req_tvalid || req_tready) begin
            // release a pause once the engine has answered everything
            if (pending_reqs.size() > 0 && pending_reqs[0].pause && expected_rsps.size() == 0)
               void'(pending_reqs.pop_front());
            if (pending_reqs.size() > 0 && !pending_reqs[0].pause &&
                $urandom_range(99) >= pending_reqs[0].tx_idle) begin
               req_in_flight = pending_reqs.pop_front();
               req_tvalid   <= 1'b1;
               req_tdata    <= {{ple_pkg::REQ_PAD_W{1'b0}}, req_in_flight.position,
                                req_in_flight.value};
               req_tuser    <= req_in_flight.mode;
               rx_stall_pct <= req_in_flight.rx_stall;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- receiver and checker

   always @(posedge clock) begin
      rsp_tready <= !reset && ($urandom_range(99) >= rx_stall_pct);
   end

   function automatic void check_field(string name, logic [ple_pkg::ELEM_W-1:0] want,
                                       logic [ple_pkg::ELEM_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      list_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_rsps.size() == 0) begin
            $error("response with no request outstanding: tdata 0x%0h", rsp_tdata);
            fail_count++;
         end else begin
            want = expected_rsps.pop_front();
            check_field("status", want.status, rsp_tdata[ple_pkg::STATUS_W-1:0]);
            check_field("element", want.element, rsp_tdata[RSP_ELEM_LO +: ple_pkg::ELEM_W]);
            check_field("has_element", want.has_element, rsp_tuser);
            check_field("length", want.length, rsp_tdata[RSP_LEN_LO +: ple_pkg::LEN_W]);
            check_field("last", want.last, rsp_tlast);
         end
      end
   end

   // ---------------------------------------------------------------- watchdog

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("positional_list_engine_tb failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      int fill_len;
      int unsigned pick;

      // empty list: dump, deletes, and inserts at bad positions
      add_request(ple_pkg::MODE_DUMP, '0, '0);
      add_request(ple_pkg::MODE_DEL_FRONT, '0, '0);
      add_request(ple_pkg::MODE_DEL_BACK, '0, '0);
      add_request(ple_pkg::MODE_DEL_AT, '0, 5'd1);
      add_request(ple_pkg::MODE_INS_AT, 32'h1234_5678, 5'd0);
      add_request(ple_pkg::MODE_INS_AT, 32'h1234_5678, 5'd2);

      // grow through every insert flavor, then check order
      add_request(ple_pkg::MODE_INS_AT, 32'h0000_0000, 5'd1);
      add_request(ple_pkg::MODE_INS_BACK, 32'hFFFF_FFFF, 5'd0);
      add_request(ple_pkg::MODE_INS_FRONT, 32'hA5A5_A5A5, 5'd31);
      add_request(ple_pkg::MODE_INS_AT, 32'h5A5A_5A5A, 5'd2);
      add_request(ple_pkg::MODE_INS_AT, 32'h0000_0001, 5'd5);
      add_request(ple_pkg::MODE_DUMP, '0, '0);
      add_request(ple_pkg::MODE_DEL_AT, '0, 5'd0);
      add_request(ple_pkg::MODE_DEL_AT, '0, 5'd6);
      add_request(ple_pkg::MODE_DEL_AT, '0, 5'd3);
      add_request(MODE_UNUSED, 32'hDEAD_BEEF, 5'd16);

      // fill to capacity
      fill_len = 4;
      while (fill_len < ple_pkg::DEPTH) begin
         pick = $urandom_range(2);
         add_request(ple_pkg::MODE_W'(int'(ple_pkg::MODE_INS_FRONT) + pick), $urandom,
                     ple_pkg::POS_W'($urandom_range(1, fill_len + 1)));
         fill_len++;
      end

      // full list: refused inserts, bad position checked before full
      add_request(ple_pkg::MODE_INS_FRONT, 32'h1111_1111, '0);
      add_request(ple_pkg::MODE_INS_BACK, 32'h2222_2222, '0);
      add_request(ple_pkg::MODE_INS_AT, 32'h3333_3333, 5'd17);
      add_request(ple_pkg::MODE_INS_AT, 32'h4444_4444, 5'd31);
      add_request(ple_pkg::MODE_DUMP, '0, '0);
      add_request(ple_pkg::MODE_DEL_AT, '0, 5'd31);
      add_request(ple_pkg::MODE_DEL_FRONT, '0, '0);
      add_request(ple_pkg::MODE_DEL_BACK, '0, '0);
      add_request(ple_pkg::MODE_DEL_AT, '0, 5'd14);

      // random phases: no idling, sender idle, receiver stall, both
      add_random_phase(0, 0, 75, 16);
      add_random_phase(73, 0, 55, 16);
      add_random_phase(0, 73, 30, 16);
      add_random_phase(30, 30, 50, 16);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // wait for the queue to empty and every response to come back
      @(negedge clock);
      while (pending_reqs.size() > 0 || req_tvalid || expected_rsps.size() > 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("positional_list_engine_tb passed");
      end else begin
         $display("positional_list_engine_tb failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/ple_pkg.sv
sv/ple_cell.sv
sv/positional_list_engine.sv
sv/ple_checker.sv
tb/positional_list_engine_tb.sv
